// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the AES cipher RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/aes_pkg.sv =====
// Types, constants and round functions for the AES block cipher.
// No dependencies; imported by every module of the cipher.
`timescale 1ns / 1ps
package aes_pkg;

    typedef struct packed {
        logic        cmd;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } t_in;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } t_out;

    // Control that travels with a block from cell to cell.
    typedef struct packed {
        logic valid;
        logic cmd;
    } t_ctl;

    localparam int NUM_CELLS = 14;
    localparam int NUM_RKEYS = 15;

    typedef logic [NUM_RKEYS-1:0][127:0] t_rkeys;

    localparam logic [2:0] CFG_KEY_SIZE   = 3'd0;
    localparam logic [2:0] CFG_KEY_PART_0 = 3'd1;
    localparam logic [2:0] CFG_KEY_PART_1 = 3'd2;
    localparam logic [2:0] CFG_KEY_PART_2 = 3'd3;
    localparam logic [2:0] CFG_KEY_PART_3 = 3'd4;

    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;

    localparam logic       CMD_ENC = 1'b0;

    localparam logic [0:255][7:0] SBOX = {
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [0:255][7:0] INV_SBOX = {
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Round count for a key-size code; code three decodes as a 256-bit key.
    function automatic logic [3:0] num_rounds(input logic [1:0] ks);
        logic [3:0] nr;
        nr = 4'd14;
        if (ks == KS_128) nr = 4'd10;
        else if (ks == KS_192) nr = 4'd12;
        return nr;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] sub_bytes(input logic [127:0] s);
        logic [127:0] o;
        for (int k = 0; k < 16; k++) o[127-8*k -: 8] = SBOX[s[127-8*k -: 8]];
        return o;
    endfunction

    function automatic logic [127:0] inv_sub_bytes(input logic [127:0] s);
        logic [127:0] o;
        for (int k = 0; k < 16; k++) o[127-8*k -: 8] = INV_SBOX[s[127-8*k -: 8]];
        return o;
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] s);
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                o[127-8*(4*c+r) -: 8] = s[127-8*(4*((c+r)&3)+r) -: 8];
        return o;
    endfunction

    function automatic logic [127:0] inv_shift_rows(input logic [127:0] s);
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                o[127-8*(4*c+r) -: 8] = s[127-8*(4*((c+4-r)&3)+r) -: 8];
        return o;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0]   a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127-32*c -: 8];
            a1 = s[119-32*c -: 8];
            a2 = s[111-32*c -: 8];
            a3 = s[103-32*c -: 8];
            o[127-32*c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            o[119-32*c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            o[111-32*c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            o[103-32*c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end
        return o;
    endfunction

    // Multiples 9, 11, 13 and 14 of a byte, packed in that order.
    function automatic logic [31:0] inv_mults(input logic [7:0] a);
        logic [7:0] x2, x4, x8;
        x2 = xt(a);
        x4 = xt(x2);
        x8 = xt(x4);
        return {x8 ^ a, x8 ^ x2 ^ a, x8 ^ x4 ^ a, x8 ^ x4 ^ x2};
    endfunction

    function automatic logic [127:0] inv_mix_cols(input logic [127:0] s);
        logic [127:0] o;
        logic [31:0]  m0, m1, m2, m3;
        for (int c = 0; c < 4; c++) begin
            m0 = inv_mults(s[127-32*c -: 8]);
            m1 = inv_mults(s[119-32*c -: 8]);
            m2 = inv_mults(s[111-32*c -: 8]);
            m3 = inv_mults(s[103-32*c -: 8]);
            // Fields: [31:24] x9, [23:16] x11, [15:8] x13, [7:0] x14.
            o[127-32*c -: 8] = m0[7:0]   ^ m1[23:16] ^ m2[15:8]  ^ m3[31:24];
            o[119-32*c -: 8] = m0[31:24] ^ m1[7:0]   ^ m2[23:16] ^ m3[15:8];
            o[111-32*c -: 8] = m0[15:8]  ^ m1[31:24] ^ m2[7:0]   ^ m3[23:16];
            o[103-32*c -: 8] = m0[23:16] ^ m1[15:8]  ^ m2[31:24] ^ m3[7:0];
        end
        return o;
    endfunction

endpackage

// ===== rtl/aes_key_expand.sv =====
// Sequential key expansion: one schedule word per cycle into round-key registers.
// Depends on aes_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module aes_key_expand (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_restart,
    input  logic [1:0]           i_key_size,
    input  logic [255:0]         i_key,
    output logic                 o_busy,
    output aes_pkg::t_rkeys      o_rkeys
);
    import aes_pkg::*;

    logic                 r_active, n_active;
    logic [5:0]           r_idx, n_idx;
    logic [2:0]           r_mod, n_mod;
    logic [7:0]           r_rcon, n_rcon;
    logic [7:0][31:0]     r_win;
    t_rkeys               r_rk;

    logic [3:0]  nk;
    logic [5:0]  total;
    logic [31:0] key_word, back_word, t, t_rot, t_sub, word;

    always_comb begin
        nk = (i_key_size == KS_128) ? 4'd4 : (i_key_size == KS_192) ? 4'd6 : 4'd8;
        total = {num_rounds(i_key_size), 2'b00} + 6'd4;
        key_word = i_key[255 - 32*r_idx[2:0] -: 32];
        back_word = (i_key_size == KS_128) ? r_win[4] :
                    (i_key_size == KS_192) ? r_win[2] : r_win[0];
        t = r_win[7];
        t_rot = {t[23:0], t[31:24]};
        t_sub = {SBOX[t_rot[31:24]] ^ r_rcon, SBOX[t_rot[23:16]],
                 SBOX[t_rot[15:8]], SBOX[t_rot[7:0]]};
        word = key_word;
        if ({2'b00, nk} <= r_idx) begin
            if (r_mod == 3'd0) begin
                word = back_word ^ t_sub;
            end else if (nk == 4'd8 && r_mod == 3'd4) begin
                word = back_word ^ {SBOX[t[31:24]], SBOX[t[23:16]],
                                    SBOX[t[15:8]], SBOX[t[7:0]]};
            end else begin
                word = back_word ^ t;
            end
        end
        n_active = r_active && (r_idx != total - 6'd1);
        n_idx = r_idx + 6'd1;
        n_mod = ({1'b0, r_mod} == nk - 4'd1) ? 3'd0 : r_mod + 3'd1;
        n_rcon = r_rcon;
        if ({2'b00, nk} <= r_idx && r_mod == 3'd0) n_rcon = xt(r_rcon);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_active <= 1'b1;
            r_idx    <= '0;
            r_mod    <= '0;
            r_rcon   <= 8'h01;
        end else if (r_active) begin
            r_active <= n_active;
            r_idx    <= n_idx;
            r_mod    <= n_mod;
            r_rcon   <= n_rcon;
        end
    end

    // The newest word enters at the top of the window.
    always_ff @(posedge i_clk) begin
        if (r_active) begin
            r_win <= {word, r_win[7:1]};
            case (r_idx[1:0])
                2'd0:    r_rk[r_idx[5:2]][127:96] <= word;
                2'd1:    r_rk[r_idx[5:2]][95:64]  <= word;
                2'd2:    r_rk[r_idx[5:2]][63:32]  <= word;
                default: r_rk[r_idx[5:2]][31:0]   <= word;
            endcase
        end
    end

    assign o_busy  = r_active;
    assign o_rkeys = r_rk;

    `ASSERT_IMPL(a_idx_in_range, i_clk, i_rst_n, r_active, r_idx < total)
    `ASSERT_NEXT(a_stays_done, i_clk, i_rst_n, !r_active && !i_restart, !r_active)
endmodule

// ===== rtl/aes_round_cell.sv =====
// One cipher round cell of the pipeline: encrypt or decrypt round, or pass-through.
// Depends on aes_pkg.
`timescale 1ns / 1ps
module aes_round_cell #(
    parameter int IDX = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  aes_pkg::t_ctl   i_ctl,
    input  logic [127:0]    i_state,
    input  logic [1:0]      i_key_size,
    input  logic [127:0]    i_rk_enc,
    input  logic [127:0]    i_rk_dec,
    output aes_pkg::t_ctl   o_ctl,
    output logic [127:0]    o_state
);
    import aes_pkg::*;

    t_ctl         r_ctl;
    logic [127:0] r_state, n_state;
    logic [3:0]   nr;
    logic         active, last;
    logic [127:0] enc_sr, dec_sub;

    always_comb begin
        nr = num_rounds(i_key_size);
        active = (4'(IDX) <= nr);
        last = (4'(IDX) == nr);
        enc_sr = shift_rows(sub_bytes(i_state));
        dec_sub = inv_sub_bytes(inv_shift_rows(i_state)) ^ i_rk_dec;
        n_state = i_state;
        if (active) begin
            if (i_ctl.cmd == CMD_ENC) begin
                n_state = (last ? enc_sr : mix_cols(enc_sr)) ^ i_rk_enc;
            end else begin
                n_state = last ? dec_sub : inv_mix_cols(dec_sub);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
    end

    assign o_ctl   = r_ctl;
    assign o_state = r_state;
endmodule

// ===== rtl/aes_block_cipher.sv =====
// Top level of the pipelined AES block cipher (128, 192 and 256-bit keys).
// Depends on aes_pkg, aes_key_expand, aes_round_cell and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
// Write the key-size code and the four key parts through the configuration
// channel (index, data, valid/ready; ready is always high). Any write starts
// the key schedule again: busy stays high while one schedule word per cycle
// is produced. After reset the all-zero key is expanded the same way, so busy
// is high after reset until that schedule is done. An item (command bit and
// 128-bit block) is taken at each edge where start is high and busy is low,
// one item per cycle. It enters a key-addition stage and then a row of 14
// round cells; shorter keys pass through the spare cells. The result appears
// after the key-addition stage and the 14 round cells, for one cycle, marked
// by o_valid. The throughput is one item per cycle while busy is low. The
// receiver cannot stall; results leave in order. Reset clears all items in
// flight.
module aes_block_cipher (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  aes_pkg::t_in   i_item,
    output logic           o_valid,
    output aes_pkg::t_out  o_result,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [2:0]     i_cfg_index,
    input  logic [63:0]    i_cfg_data
);
    import aes_pkg::*;

    logic [1:0]        r_key_size;
    logic [3:0][63:0]  r_key_part;
    logic              cfg_wr, accept, exp_busy;
    t_rkeys            rkeys;
    logic [3:0]        nr;
    logic [127:0]      in_state, rk_first;

    t_ctl              r_ctl0;
    logic [127:0]      r_state0;

    t_ctl              ctl_chain   [NUM_CELLS+1];
    logic [127:0]      state_chain [NUM_CELLS+1];

    assign o_cfg_ready = 1'b1;
    assign cfg_wr = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_size <= '0;
            r_key_part <= '0;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_KEY_SIZE:   r_key_size    <= i_cfg_data[1:0];
                CFG_KEY_PART_0: r_key_part[3] <= i_cfg_data;
                CFG_KEY_PART_1: r_key_part[2] <= i_cfg_data;
                CFG_KEY_PART_2: r_key_part[1] <= i_cfg_data;
                CFG_KEY_PART_3: r_key_part[0] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    aes_key_expand u_key_expand (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (cfg_wr),
        .i_key_size (r_key_size),
        .i_key      (r_key_part),
        .o_busy     (exp_busy),
        .o_rkeys    (rkeys)
    );

    assign busy   = exp_busy;
    assign accept = start && !exp_busy;

    // Initial key addition: round key 0 to encrypt, the last one to decrypt.
    always_comb begin
        nr = num_rounds(r_key_size);
        in_state = {i_item.block_high, i_item.block_low};
        rk_first = rkeys[0];
        if (i_item.cmd != CMD_ENC) begin
            rk_first = (nr == 4'd10) ? rkeys[10] : (nr == 4'd12) ? rkeys[12] : rkeys[14];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
        end else begin
            r_ctl0 <= '{valid: accept, cmd: i_item.cmd};
        end
    end

    always_ff @(posedge i_clk) begin
        r_state0 <= in_state ^ rk_first;
    end

    assign ctl_chain[0]   = r_ctl0;
    assign state_chain[0] = r_state0;

    for (genvar g = 1; g <= NUM_CELLS; g++) begin : g_cell
        localparam int D10 = (g <= 10) ? 10 - g : 0;
        localparam int D12 = (g <= 12) ? 12 - g : 0;
        localparam int D14 = 14 - g;
        logic [127:0] rk_dec;

        always_comb begin
            unique case (r_key_size)
                KS_128:  rk_dec = rkeys[D10];
                KS_192:  rk_dec = rkeys[D12];
                default: rk_dec = rkeys[D14];
            endcase
        end

        aes_round_cell #(.IDX(g)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl_chain[g-1]),
            .i_state    (state_chain[g-1]),
            .i_key_size (r_key_size),
            .i_rk_enc   (rkeys[g]),
            .i_rk_dec   (rk_dec),
            .o_ctl      (ctl_chain[g]),
            .o_state    (state_chain[g])
        );
    end

    assign o_valid  = ctl_chain[NUM_CELLS].valid;
    assign o_result = '{result_high: state_chain[NUM_CELLS][127:64],
                        result_low:  state_chain[NUM_CELLS][63:0]};

    `ASSERT_NEXT(a_latency, i_clk, i_rst_n, start && !busy, ##14 o_valid)
    `ASSERT_IMPL(a_no_spurious, i_clk, i_rst_n, o_valid, $past(start && !busy, 15))
    `ASSERT_IMPL(a_cfg_restarts, i_clk, i_rst_n, $past(i_cfg_valid) && $past(i_rst_n), busy)
endmodule

// ===== tb/aes_block_cipher_tb.sv =====
// Self-checking testbench for the pipelined AES block cipher (ECB, 128/192/256-bit keys).
// Depends on aes_pkg and aes_block_cipher; holds its own AES predictor for every block.
`timescale 1ns / 1ps
module aes_block_cipher_tb;
    import aes_pkg::*;

    localparam logic       CMD_DEC        = 1'b1;
    localparam logic [1:0] KS_256         = 2'd2;
    localparam logic [1:0] KS_UNDEFINED   = 2'd3;
    localparam logic [2:0] CFG_NONE_FIRST = 3'd5;
    localparam int         DRAIN_CYCLES   = 20;
    localparam int         STALL_LIMIT    = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in         i_item = '0;
    logic        o_valid;
    t_out        o_result;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    aes_block_cipher dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_valid(o_valid), .o_result(o_result), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the key registers.
    logic [1:0]  key_sz = KS_128;
    logic [63:0] key_word [0:3] = '{default: '0};

    logic [7:0] fwd_box [0:255];
    logic [7:0] rev_box [0:255];

    t_out cipher_q [$];
    int   fail_cnt = 0;
    int   idle_pct = 0;
    int   stall_cnt = 0;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    // The S-box is derived from the field inverse and the affine map.
    task automatic build_boxes();
        logic [7:0] v, b;
        for (int x = 0; x < 256; x++) begin
            v = '0;
            for (int y = 1; y < 256; y++)
                if (gf_mul(8'(x), 8'(y)) == 8'h01) v = 8'(y);
            b = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
                ^ {v[3:0], v[7:4]} ^ 8'h63;
            fwd_box[x] = b;
            rev_box[b] = 8'(x);
        end
    endtask

    function automatic logic [127:0] st_sub(input logic [127:0] s, input bit inv);
        for (int k = 0; k < 16; k++)
            s[127-8*k -: 8] = inv ? rev_box[s[127-8*k -: 8]] : fwd_box[s[127-8*k -: 8]];
        return s;
    endfunction

    function automatic logic [127:0] st_shift(input logic [127:0] s, input bit inv);
        logic [127:0] o;
        int src;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                src = inv ? ((c + 4 - r) & 3) : ((c + r) & 3);
                o[127-8*(4*c+r) -: 8] = s[127-8*(4*src+r) -: 8];
            end
        return o;
    endfunction

    function automatic logic [127:0] st_mix(input logic [127:0] s, input bit inv);
        logic [7:0]   m [0:3];
        logic [7:0]   acc;
        logic [127:0] o;
        if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
        else     m = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                acc = '0;
                for (int j = 0; j < 4; j++)
                    acc ^= gf_mul(s[127-8*(4*c+j) -: 8], m[(4 + j - r) & 3]);
                o[127-8*(4*c+r) -: 8] = acc;
            end
        return o;
    endfunction

    function automatic t_out aes_predict(input t_in it);
        logic [7:0]   kb [0:31];
        logic [7:0]   w [0:59][0:3];
        logic [7:0]   t [0:3];
        logic [7:0]   tmp, rc;
        logic [127:0] rk [0:14];
        logic [127:0] st;
        int           nk, nr;
        for (int i = 0; i < 32; i++) kb[i] = key_word[i >> 3][63-8*(i & 7) -: 8];
        if (key_sz == KS_128) begin nk = 4; nr = 10; end
        else if (key_sz == KS_192) begin nk = 6; nr = 12; end
        else begin nk = 8; nr = 14; end
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            for (int j = 0; j < 4; j++) w[i][j] = kb[4*i+j];
        for (int i = nk; i < 4 * (nr + 1); i++) begin
            t = w[i-1];
            if (i % nk == 0) begin
                tmp = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = tmp;
                for (int j = 0; j < 4; j++) t[j] = fwd_box[t[j]];
                t[0] ^= rc;
                rc = gf_mul(rc, 8'h02);
            end else if (nk > 6 && i % nk == 4) begin
                for (int j = 0; j < 4; j++) t[j] = fwd_box[t[j]];
            end
            for (int j = 0; j < 4; j++) w[i][j] = w[i-nk][j] ^ t[j];
        end
        for (int r = 0; r <= nr; r++)
            for (int q = 0; q < 4; q++)
                for (int j = 0; j < 4; j++) rk[r][127-8*(4*q+j) -: 8] = w[4*r+q][j];
        st = {it.block_high, it.block_low};
        if (it.cmd == CMD_ENC) begin
            st ^= rk[0];
            for (int r = 1; r <= nr; r++) begin
                st = st_shift(st_sub(st, 1'b0), 1'b0);
                if (r != nr) st = st_mix(st, 1'b0);
                st ^= rk[r];
            end
        end else begin
            st ^= rk[nr];
            for (int r = nr - 1; r >= 0; r--) begin
                st = st_sub(st_shift(st, 1'b1), 1'b1) ^ rk[r];
                if (r != 0) st = st_mix(st, 1'b1);
            end
        end
        return '{result_high: st[127:64], result_low: st[63:0]};
    endfunction

    // Results leave in order, one per item; the receiver cannot stall.
    always @(posedge i_clk) begin
        t_out exp_blk;
        if (i_rst_n && o_valid) begin
            if (cipher_q.size() == 0) begin
                $error("result_high/result_low: no block expected, got %h %h",
                       o_result.result_high, o_result.result_low);
                fail_cnt++;
            end else begin
                exp_blk = cipher_q.pop_front();
                if (o_result.result_high !== exp_blk.result_high) begin
                    $error("result_high: expected %h, got %h",
                           exp_blk.result_high, o_result.result_high);
                    fail_cnt++;
                end
                if (o_result.result_low !== exp_blk.result_low) begin
                    $error("result_low: expected %h, got %h",
                           exp_blk.result_low, o_result.result_low);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("** aes_block_cipher: FAILED **");
            $finish;
        end
    end

    // Each cycle before an item is left idle with the chance given by idle_pct.
    task automatic push_block(input t_in it);
        while ($urandom_range(99) < idle_pct)
            @(negedge i_clk) start <= 1'b0;
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        cipher_q.push_back(aes_predict(it));
    endtask

    task automatic drain();
        @(negedge i_clk) start <= 1'b0;
        while (cipher_q.size() != 0) @(posedge i_clk);
    endtask

    // Writes happen only with the pipeline empty.
    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_KEY_SIZE:   key_sz = data[1:0];
            CFG_KEY_PART_0: key_word[0] = data;
            CFG_KEY_PART_1: key_word[1] = data;
            CFG_KEY_PART_2: key_word[2] = data;
            CFG_KEY_PART_3: key_word[3] = data;
            default: ;
        endcase
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    task automatic load_key(input logic [1:0] ks, input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3);
        drain();
        cfg_write(CFG_KEY_SIZE, {62'd0, ks});
        cfg_write(CFG_KEY_PART_0, k0);
        cfg_write(CFG_KEY_PART_1, k1);
        cfg_write(CFG_KEY_PART_2, k2);
        cfg_write(CFG_KEY_PART_3, k3);
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_in rand_block();
        return '{cmd: 1'($urandom_range(1)), block_high: rand64(), block_low: rand64()};
    endfunction

    task automatic both_ways(input logic [63:0] hi, input logic [63:0] lo);
        push_block('{cmd: CMD_ENC, block_high: hi, block_low: lo});
        push_block('{cmd: CMD_DEC, block_high: hi, block_low: lo});
    endtask

    task automatic test_reset_key();
        both_ways('0, '0);
        both_ways('1, '1);
    endtask

    task automatic test_standard_vectors();
        load_key(KS_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
        both_ways(64'h0011223344556677, 64'h8899aabbccddeeff);
        load_key(KS_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, '1);
        both_ways(64'h0011223344556677, 64'h8899aabbccddeeff);
        load_key(KS_256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        both_ways(64'h0011223344556677, 64'h8899aabbccddeeff);
        both_ways('1, '0);
    endtask

    task automatic test_undefined_key_size();
        load_key(KS_UNDEFINED, '1, '1, '1, '1);
        both_ways(64'h0011223344556677, 64'h8899aabbccddeeff);
        both_ways('0, '1);
    endtask

    task automatic test_unused_index();
        drain();
        for (int i = CFG_NONE_FIRST; i < 8; i++) cfg_write(3'(i), '1);
        both_ways('0, '0);
    endtask

    task automatic test_random_blocks();
        int phase_pct [0:3] = '{0, 56, 0, 32};
        for (int p = 0; p < 16; p++) begin
            load_key(2'($urandom_range(3)), rand64(), rand64(), rand64(), rand64());
            idle_pct = phase_pct[p % 4];
            for (int n = 0; n < 95; n++) begin
                push_block(rand_block());
                // Let the pipeline run dry once mid-stream.
                if (p == 5 && n == 40) drain();
            end
        end
        idle_pct = 0;
    endtask

    initial begin
        build_boxes();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        test_reset_key();
        test_standard_vectors();
        test_undefined_key_size();
        test_unused_index();
        test_random_blocks();
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && cipher_q.size() == 0)
            $display("** aes_block_cipher: PASSED **");
        else
            $display("** aes_block_cipher: FAILED **");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/aes_pkg.sv
rtl/aes_key_expand.sv
rtl/aes_round_cell.sv
rtl/aes_block_cipher.sv
tb/aes_block_cipher_tb.sv
